FILE: hdl/etpc_pkg.sv
// shared types, constants and helper functions for the escape-time pixel colorizer
package etpc_pkg;

   localparam int FRAC_BITS        = 28;
   localparam int COLORMAP_SIZE_DEF = 512;
   localparam int FIX_W            = 32;
   localparam int PROD_W           = 2 * FIX_W;
   localparam int WIDE_W           = PROD_W + 2;
   // a floored square is below 2^(62-FRAC_BITS)+1
   localparam int SQ_W             = PROD_W - 1 - FRAC_BITS;

   typedef logic signed [FIX_W-1:0]  fix_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [WIDE_W-1:0] wide_type;
   typedef logic [SQ_W-1:0]          sq_type;
   typedef logic [30:0]              step_type;
   typedef logic [15:0]              iter_type;
   typedef logic [11:0]              pixel_type;
   typedef logic [23:0]              rgb_type;
   typedef logic [2:0]               csr_index_type;
   typedef logic [31:0]              csr_data_type;

   localparam csr_index_type CSR_ORIGIN_REAL = 3'd0;
   localparam csr_index_type CSR_ORIGIN_IMAG = 3'd1;
   localparam csr_index_type CSR_STEP_REAL   = 3'd2;
   localparam csr_index_type CSR_STEP_IMAG   = 3'd3;
   localparam csr_index_type CSR_MAX_ITER    = 3'd4;

   localparam iter_type MAX_ITER_RESET = 16'd1024;
   localparam rgb_type  COLOR_BLACK    = 24'h000000;

   // escape bound 4.0 against the sum of two floored squares
   localparam logic [SQ_W:0] ESC_LIMIT = (SQ_W+1)'(64'd4 << FRAC_BITS);

   localparam fix_type FIX_MAX = 32'sh7FFF_FFFF;
   localparam fix_type FIX_MIN = 32'sh8000_0000;

   // clamp a wide signed value to the 32-bit signed range
   function automatic fix_type sat32(input wide_type v);
      fix_type r;
      if (v > WIDE_W'(FIX_MAX)) begin
         r = FIX_MAX;
      end else if (v < WIDE_W'(FIX_MIN)) begin
         r = FIX_MIN;
      end else begin
         r = v[FIX_W-1:0];
      end
      return r;
   endfunction

endpackage

FILE: hdl/etpc_req_if.sv
// request channel: one pixel coordinate pair per transaction
interface etpc_req_if;
   import etpc_pkg::*;

   logic      valid;
   logic      ready;
   pixel_type pixel_col;
   pixel_type pixel_row;

   modport source (output valid, output pixel_col, output pixel_row, input ready);
   modport sink   (input valid, input pixel_col, input pixel_row, output ready);
endinterface

FILE: hdl/etpc_rsp_if.sv
// response channel: one colored pixel per transaction
interface etpc_rsp_if;
   import etpc_pkg::*;

   logic     valid;
   logic     ready;
   rgb_type  color_rgb;
   iter_type iter_count;
   logic     inside_set;

   modport source (output valid, output color_rgb, output iter_count, output inside_set,
                   input ready);
   modport sink   (input valid, input color_rgb, input iter_count, input inside_set,
                   output ready);
endinterface

FILE: hdl/escape_time_pixel_colorizer_core.sv
// Mandelbrot escape-time colorizer: one pixel in, one color out. The pixel is mapped to
// c = (origin + col*step_real, origin + row*step_imag) in signed Q4.28, then z = z*z + c is
// iterated from zero until |z|^2 reaches 4.0 or the count reaches max_iter. A single shared
// 32x32 multiplier does every product, so an iteration is split into steps: cross term,
// x^2, y^2 and the update. A pixel that escapes then goes through a serial divide for its
// colormap index; a pixel that reaches the limit (default 1024) skips the divide. The
// block takes one pixel at a time: req ready is high only while it is idle, and a finished
// result waiting in the output register does not block the next pixel from being taken.
// Configuration registers are to be written only while idle: the user must ensure this;
// the block itself does not enforce it.
module escape_time_pixel_colorizer_core #(
   parameter int COLORMAP_SIZE = etpc_pkg::COLORMAP_SIZE_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   etpc_req_if.sink                req_chan,
   etpc_rsp_if.source              rsp_chan,
   input  logic                    csr_wr_en,
   input  etpc_pkg::csr_index_type csr_index,
   input  etpc_pkg::csr_data_type  csr_wr_data
);
   import etpc_pkg::*;

   // quotient width of the colormap index, index is below COLORMAP_SIZE
   localparam int QW = $clog2(COLORMAP_SIZE);
   localparam int DW = 16 + QW;
   localparam logic signed [14:0] HALF_CM = 15'(COLORMAP_SIZE / 2);

   // sequencer codes
   localparam logic [3:0] S_IDLE = 4'd0;   // wait for a pixel
   localparam logic [3:0] S_CR   = 4'd1;   // multiply col*step_real
   localparam logic [3:0] S_CI   = 4'd2;   // form cr, multiply row*step_imag
   localparam logic [3:0] S_CIW  = 4'd3;   // form ci, clear z
   localparam logic [3:0] S_MXY  = 4'd4;   // first cross product
   localparam logic [3:0] S_NEW  = 4'd5;   // z update
   localparam logic [3:0] S_MXX  = 4'd6;   // multiply x*x
   localparam logic [3:0] S_MYY  = 4'd7;   // take x^2, multiply y*y
   localparam logic [3:0] S_SQ   = 4'd8;   // take y^2, escape test, next cross product
   localparam logic [3:0] S_FIN  = 4'd9;   // start index divide unless inside
   localparam logic [3:0] S_DIVW = 4'd10;  // wait for divider
   localparam logic [3:0] S_OUT  = 4'd11;  // load output register

   // configuration
   fix_type  origin_real_ff;
   fix_type  origin_imag_ff;
   step_type step_real_ff;
   step_type step_imag_ff;
   iter_type max_iter_ff;

   // sequencer and datapath state
   logic [3:0] state_ff, state_in;
   pixel_type  col_ff, col_in;
   pixel_type  row_ff, row_in;
   fix_type    cr_ff, cr_in;
   fix_type    ci_ff, ci_in;
   fix_type    x_ff, x_in;
   fix_type    y_ff, y_in;
   sq_type     xx_ff, xx_in;
   sq_type     yy_ff, yy_in;
   iter_type   count_ff, count_in;

   // output register
   logic     rsp_valid_ff, rsp_valid_in;
   rgb_type  rsp_color_ff, rsp_color_in;
   iter_type rsp_count_ff, rsp_count_in;
   logic     rsp_inside_ff, rsp_inside_in;

   // shared multiplier
   fix_type  mul_a;
   fix_type  mul_b;
   prod_type prod_ff;

   // divider
   logic          div_start;
   logic          div_busy;
   logic [QW-1:0] div_quo;
   logic [DW-1:0] div_num;

   // datapath terms
   wide_type       prod_ext;
   prod_type       cross_term;
   wide_type       coord_sum;
   wide_type       new_x_wide;
   wide_type       new_y_wide;
   prod_type       sq_shift;
   sq_type         sq_new;
   logic [SQ_W:0]  mag_sum;
   logic           keep_going;
   logic           out_free;
   logic           limit_hit;

   // colormap entry, each channel masked to 8 bits
   function automatic rgb_type palette(input logic [QW-1:0] idx);
      logic signed [14:0] iv;
      logic signed [14:0] rv;
      logic signed [14:0] gv;
      logic signed [14:0] bv;
      logic [8:0]         dsum;
      logic [7:0]         r8;
      logic [7:0]         g8;
      logic [7:0]         b8;
      iv = $signed(15'(idx));
      rv = iv - HALF_CM + 15'sd192;
      gv = (iv * 15'sd3) >>> 1;
      bv = HALF_CM - (iv <<< 1);
      if (rv < 15'sd0) begin
         rv = 15'sd0;
      end
      // mod 255 as a digit sum in base 256, one correction
      dsum = {1'b0, rv[7:0]} + 9'(rv[14:8]);
      if (dsum >= 9'd255) begin
         dsum = dsum - 9'd255;
      end
      if (rv > 15'sd255) begin
         r8 = rv[7:0] - {dsum[6:0], 1'b0};
      end else begin
         r8 = rv[7:0];
      end
      if (gv > 15'sd255) begin
         g8 = (gv < 15'sd384) ? {8'(8'd255 - gv[7:0])} << 1 : 8'd0;
      end else begin
         g8 = gv[7:0];
      end
      if (bv < 15'sd0) begin
         b8 = (bv < -15'sd512) ? 8'(8'd0 - bv[7:0]) : 8'd0;
      end else begin
         b8 = bv[7:0];
      end
      return {r8, g8, b8};
   endfunction

   etpc_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod_ff)
   );

   etpc_div #(.QW(QW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (max_iter_ff),
      .busy     (div_busy),
      .quotient (div_quo)
   );

   // multiplier operand select by sequencer step
   always_comb begin
      case (state_ff)
         S_CR: begin
            mul_a = fix_type'({20'd0, col_ff});
            mul_b = fix_type'({1'b0, step_real_ff});
         end
         S_CI: begin
            mul_a = fix_type'({20'd0, row_ff});
            mul_b = fix_type'({1'b0, step_imag_ff});
         end
         S_MXX: begin
            mul_a = x_ff;
            mul_b = x_ff;
         end
         S_MYY: begin
            mul_a = y_ff;
            mul_b = y_ff;
         end
         default: begin
            mul_a = x_ff;
            mul_b = y_ff;
         end
      endcase
   end

   // wide sums around the product register
   assign prod_ext   = {{2{prod_ff[PROD_W-1]}}, prod_ff};
   // 2*x*y: floor shift by one bit less
   assign cross_term = prod_ff >>> (FRAC_BITS - 1);
   assign sq_shift   = prod_ff >>> FRAC_BITS;
   assign sq_new     = sq_shift[SQ_W-1:0];
   // coordinate: origin plus col/row times step, shared for both axes
   assign coord_sum  = prod_ext + ((state_ff == S_CI) ?
                          {{(WIDE_W-FIX_W){origin_real_ff[FIX_W-1]}}, origin_real_ff} :
                          {{(WIDE_W-FIX_W){origin_imag_ff[FIX_W-1]}}, origin_imag_ff});
   assign new_x_wide = $signed({{(WIDE_W-SQ_W){1'b0}}, xx_ff})
                     - $signed({{(WIDE_W-SQ_W){1'b0}}, yy_ff})
                     + {{(WIDE_W-FIX_W){cr_ff[FIX_W-1]}}, cr_ff};
   assign new_y_wide = {{2{cross_term[PROD_W-1]}}, cross_term}
                     + {{(WIDE_W-FIX_W){ci_ff[FIX_W-1]}}, ci_ff};
   // escape test uses the y^2 that arrives this cycle
   assign mag_sum    = {1'b0, xx_ff} + {1'b0, sq_new};
   assign keep_going = (mag_sum < ESC_LIMIT) && (count_ff < max_iter_ff);

   assign limit_hit  = (count_ff == max_iter_ff);
   assign div_num    = DW'(count_ff) * DW'(COLORMAP_SIZE);
   assign div_start  = (state_ff == S_FIN) && !limit_hit;
   assign out_free   = !rsp_valid_ff || rsp_chan.ready;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      cr_in         = cr_ff;
      ci_in         = ci_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      xx_in         = xx_ff;
      yy_in         = yy_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_color_in  = rsp_color_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_inside_in = rsp_inside_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               col_in   = req_chan.pixel_col;
               row_in   = req_chan.pixel_row;
               state_in = S_CR;
            end
         end
         S_CR: begin
            state_in = S_CI;
         end
         S_CI: begin
            cr_in    = sat32(coord_sum);
            state_in = S_CIW;
         end
         S_CIW: begin
            ci_in    = sat32(coord_sum);
            x_in     = '0;
            y_in     = '0;
            xx_in    = '0;
            yy_in    = '0;
            count_in = '0;
            // z starts at zero, so only the limit can stop the first pass
            state_in = (max_iter_ff == '0) ? S_FIN : S_MXY;
         end
         S_MXY: begin
            state_in = S_NEW;
         end
         S_NEW: begin
            x_in     = sat32(new_x_wide);
            y_in     = sat32(new_y_wide);
            count_in = count_ff + 16'd1;
            state_in = S_MXX;
         end
         S_MXX: begin
            state_in = S_MYY;
         end
         S_MYY: begin
            xx_in    = sq_new;
            state_in = S_SQ;
         end
         S_SQ: begin
            yy_in    = sq_new;
            state_in = keep_going ? S_NEW : S_FIN;
         end
         S_FIN: begin
            state_in = limit_hit ? S_OUT : S_DIVW;
         end
         S_DIVW: begin
            if (!div_busy) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_color_in  = limit_hit ? COLOR_BLACK : palette(div_quo);
               rsp_count_in  = count_ff;
               rsp_inside_in = limit_hit;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      col_ff        <= col_in;
      row_ff        <= row_in;
      cr_ff         <= cr_in;
      ci_ff         <= ci_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      xx_ff         <= xx_in;
      yy_ff         <= yy_in;
      count_ff      <= count_in;
      rsp_color_ff  <= rsp_color_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_inside_ff <= rsp_inside_in;
   end

   // configuration registers, writes beyond the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_real_ff <= '0;
         origin_imag_ff <= '0;
         step_real_ff   <= '0;
         step_imag_ff   <= '0;
         max_iter_ff    <= MAX_ITER_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_ORIGIN_REAL: origin_real_ff <= csr_wr_data;
            CSR_ORIGIN_IMAG: origin_imag_ff <= csr_wr_data;
            CSR_STEP_REAL:   step_real_ff   <= csr_wr_data[30:0];
            CSR_STEP_IMAG:   step_imag_ff   <= csr_wr_data[30:0];
            CSR_MAX_ITER:    max_iter_ff    <= csr_wr_data[15:0];
            default: begin
            end
         endcase
      end
   end

   // channel hookup
   assign req_chan.ready      = (state_ff == S_IDLE);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.color_rgb  = rsp_color_ff;
   assign rsp_chan.iter_count = rsp_count_ff;
   assign rsp_chan.inside_set = rsp_inside_ff;

   // loop never runs past the limit
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN) |-> (count_ff <= max_iter_ff))
      else $error("iteration count beyond limit");

   // an inside pixel is black and carries the full count
   a_inside_black: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_inside_ff) |->
         (rsp_color_ff == COLOR_BLACK && rsp_count_ff == max_iter_ff))
      else $error("inside pixel not black or count off");

   // divider is never restarted while busy
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider restarted while busy");

   // a new result only comes from the output step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_OUT))
      else $error("result raised outside output step");
endmodule

FILE: hdl/etpc_mul.sv
// shared signed 32x32 multiplier with registered product
module etpc_mul (
   input  logic              clock,
   input  etpc_pkg::fix_type mul_a,
   input  etpc_pkg::fix_type mul_b,
   output etpc_pkg::prod_type prod_ff
);
   import etpc_pkg::*;

   prod_type prod_in;

   assign prod_in = prod_type'(mul_a) * prod_type'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end
endmodule

FILE: hdl/etpc_div.sv
// restoring divider, one quotient bit per cycle, quotient known to fit QW bits
module etpc_div #(
   parameter int QW = $clog2(etpc_pkg::COLORMAP_SIZE_DEF)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [16+QW-1:0]   dividend,
   input  etpc_pkg::iter_type divisor,
   output logic               busy,
   output logic [QW-1:0]      quotient
);
   import etpc_pkg::*;

   localparam int CW = $clog2(QW + 1);

   logic [15:0]   rem_ff,  rem_in;
   logic [QW-1:0] low_ff,  low_in;
   logic [QW-1:0] quo_ff,  quo_in;
   logic [CW-1:0] cnt_ff,  cnt_in;
   logic          busy_ff, busy_in;
   logic [16:0]   trial;
   logic [16:0]   diff;
   logic          ge;

   assign trial = {rem_ff, low_ff[QW-1]};
   assign diff  = trial - {1'b0, divisor};
   assign ge    = (trial >= {1'b0, divisor});

   always_comb begin
      rem_in  = rem_ff;
      low_in  = low_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         // upper part is already below the divisor
         rem_in  = dividend[16+QW-1:QW];
         low_in  = dividend[QW-1:0];
         cnt_in  = CW'(QW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[15:0] : trial[15:0];
         low_in  = {low_ff[QW-2:0], 1'b0};
         quo_in  = {quo_ff[QW-2:0], ge};
         cnt_in  = cnt_ff - CW'(1);
         busy_in = (cnt_ff != CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;
endmodule
